/* rtl/bpadb_pkg.sv */
// Shared constants, codes and word types for the bin power averager.
package bpadb_pkg;

   // Bin store geometry
   localparam int BINS  = 64;
   localparam int BIN_W = 6;

   // Field and register widths
   localparam int CNT_W     = 7;
   localparam int TGT_W     = 17;
   localparam int CSR_W     = 17;
   localparam int CSR_IDX_W = 1;
   localparam int POW_W     = 32;
   localparam int FREQ_W    = 40;
   localparam int SUM_W     = 48;
   localparam int DB_W      = 16;

   // Register reset values
   localparam logic [CNT_W-1:0] BIN_COUNT_RST    = 7'd64;
   localparam logic [TGT_W-1:0] BLOCK_TARGET_RST = 17'd1;

   // Saturation level of a bin sum
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // Log and dB arithmetic
   localparam int MANT_W   = 31;     // Q1.30 mantissa
   localparam int FRAC_W   = 16;     // fraction bits of log2
   localparam int SE_W     = 6;      // exponent of a bin sum
   localparam int DE_W     = 5;      // exponent of the block count
   localparam int LOG_OFS  = 24;     // fraction bits of the Q8.24 input
   localparam int D_W      = 24;     // signed log difference
   localparam int ABS_W    = D_W - 1;
   localparam int C_W      = 18;
   localparam int MAG_W    = ABS_W + C_W;
   localparam int DB_SHIFT = 24;     // Q16 x Q16 down to Q8
   localparam logic [C_W-1:0]  DB_C    = 18'd197283;  // 10*log10(2) in Q16
   localparam logic [DB_W-2:0] DB_MAX  = 15'h7FFF;
   localparam logic [DB_W-1:0] DB_ZERO = 16'h8000;

   // Input function codes
   typedef enum logic {
      FUNC_SAMPLE = 1'b0,
      FUNC_BEGIN  = 1'b1
   } func_type;

   // Result kind codes
   typedef enum logic {
      KIND_BIN   = 1'b0,
      KIND_BEGIN = 1'b1
   } kind_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIN_COUNT    = 1'b0,
      CSR_BLOCK_TARGET = 1'b1
   } csr_type;

   // Fields that ride with a result through the dB pipeline
   typedef struct packed {
      kind_type           kind;
      logic [BIN_W-1:0]   bin;
      logic               accepted;
      logic               zero;
   } meta_type;

   // Word handed from the accumulator to the dB pipeline
   typedef struct packed {
      meta_type           meta;
      logic [SUM_W-1:0]   sum;
      logic [TGT_W-1:0]   div;
   } job_type;

endpackage

/* rtl/bpadb_acc.sv */
// Bin sum store with read-modify-write, block counting and begin handling.
module bpadb_acc (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [bpadb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpadb_pkg::CSR_W-1:0]       csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [bpadb_pkg::BIN_W-1:0]       req_bin_index,
   input  logic [bpadb_pkg::POW_W-1:0]       req_linear_power,
   input  logic [bpadb_pkg::FREQ_W-1:0]      req_frequency,
   output logic                              job_valid,
   input  logic                              job_ready,
   output bpadb_pkg::job_type                job
);
   import bpadb_pkg::*;

   logic [CNT_W-1:0]  bin_count_ff, bin_count_in;
   logic [TGT_W-1:0]  block_target_ff, block_target_in;
   logic [TGT_W-1:0]  blocks_done_ff, blocks_done_in;
   logic [FREQ_W-1:0] cur_freq_ff, cur_freq_in;
   logic [BINS-1:0]   vld_ff, vld_in;

   logic              s1_v_ff, s1_v_in;
   logic              s1_func_ff;
   logic [BIN_W-1:0]  s1_bin_ff;
   logic [POW_W-1:0]  s1_power_ff;
   logic [FREQ_W-1:0] s1_freq_ff;
   logic [SUM_W-1:0]  rd_ff;
   logic              hit_ff, hit_in;
   logic [SUM_W-1:0]  fwd_ff, fwd_in;

   logic [SUM_W-1:0]  sum_mem [BINS];

   logic [CNT_W-1:0]  eff;
   logic              in_range, last_bin, is_begin, is_sample, begin_ok;
   logic              final_blk, produce, s1_adv, fire, accept, mem_we;
   logic [SUM_W-1:0]  old_sum, sum_sat, mem_wdata;
   logic [SUM_W:0]    sum_wide;
   logic [TGT_W:0]    done_inc;

   // Decode configuration writes
   always_comb begin
      bin_count_in    = bin_count_ff;
      block_target_in = block_target_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_BIN_COUNT:    bin_count_in    = csr_write_data[CNT_W-1:0];
            CSR_BLOCK_TARGET: block_target_in = csr_write_data[TGT_W-1:0];
            default: ;
         endcase
      end
   end

   // Evaluate the word held after the store read
   always_comb begin
      eff       = (bin_count_ff > CNT_W'(BINS)) ? CNT_W'(BINS) : bin_count_ff;
      in_range  = (eff != '0) && (block_target_ff != '0) && (CNT_W'(s1_bin_ff) < eff);
      last_bin  = CNT_W'(s1_bin_ff) == (eff - CNT_W'(1));
      is_begin  = s1_func_ff == FUNC_BEGIN;
      is_sample = !is_begin && in_range;
      begin_ok  = !((blocks_done_ff != '0) && (cur_freq_ff == s1_freq_ff));

      // take the newest value of the bin: forwarded, stored, or cleared
      old_sum   = hit_ff ? fwd_ff : (vld_ff[s1_bin_ff] ? rd_ff : '0);
      sum_wide  = {1'b0, old_sum} + (SUM_W+1)'(s1_power_ff);
      sum_sat   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

      done_inc  = {1'b0, blocks_done_ff} + (TGT_W+1)'(1);
      final_blk = done_inc >= {1'b0, block_target_ff};

      produce   = is_begin || (is_sample && final_blk);
      job_valid = s1_v_ff && produce;
      s1_adv    = !s1_v_ff || !produce || job_ready;
      fire      = s1_v_ff && s1_adv;
      accept    = req_valid && s1_adv;
      req_ready = s1_adv;

      mem_we    = fire && is_sample;
      mem_wdata = final_blk ? '0 : sum_sat;
   end

   // Build the outgoing word
   always_comb begin
      job.meta.kind     = is_begin ? KIND_BEGIN : KIND_BIN;
      job.meta.bin      = is_begin ? '0 : s1_bin_ff;
      job.meta.accepted = is_begin && begin_ok;
      job.meta.zero     = sum_sat == '0;
      job.sum           = sum_sat;
      job.div           = done_inc[TGT_W-1:0];
   end

   // Advance block count, frequency and store valid bits
   always_comb begin
      blocks_done_in = blocks_done_ff;
      cur_freq_in    = cur_freq_ff;
      vld_in         = vld_ff;
      if (fire) begin
         if (is_begin) begin
            if (begin_ok) begin
               blocks_done_in = '0;
               cur_freq_in    = s1_freq_ff;
               vld_in         = '0;
            end
         end else if (in_range) begin
            vld_in[s1_bin_ff] = 1'b1;
            if (last_bin) begin
               blocks_done_in = final_blk ? '0 : done_inc[TGT_W-1:0];
            end
         end
      end
   end

   // Forward a write that the next word's read misses
   always_comb begin
      s1_v_in = s1_adv ? req_valid : s1_v_ff;
      hit_in  = mem_we && (s1_bin_ff == req_bin_index);
      fwd_in  = mem_wdata;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff    <= BIN_COUNT_RST;
         block_target_ff <= BLOCK_TARGET_RST;
         blocks_done_ff  <= '0;
         cur_freq_ff     <= '0;
         vld_ff          <= '0;
         s1_v_ff         <= 1'b0;
      end else begin
         bin_count_ff    <= bin_count_in;
         block_target_ff <= block_target_in;
         blocks_done_ff  <= blocks_done_in;
         cur_freq_ff     <= cur_freq_in;
         vld_ff          <= vld_in;
         s1_v_ff         <= s1_v_in;
      end
   end

   // Capture the accepted word and its forwarding info
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff  <= req_func;
         s1_bin_ff   <= req_bin_index;
         s1_power_ff <= req_linear_power;
         s1_freq_ff  <= req_frequency;
         hit_ff      <= hit_in;
         fwd_ff      <= fwd_in;
      end
   end

   // Sum store: write back behind, read ahead
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[s1_bin_ff] <= mem_wdata;
      end
      if (accept) begin
         rd_ff <= sum_mem[req_bin_index];
      end
   end

endmodule

/* rtl/bpadb_db_pipe.sv */
// Elastic pipeline turning a bin sum and block count into Q8.8 dB.
module bpadb_db_pipe (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_valid,
   output logic                              job_ready,
   input  bpadb_pkg::job_type                job,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_kind,
   output logic [bpadb_pkg::BIN_W-1:0]       rsp_out_bin,
   output logic signed [bpadb_pkg::DB_W-1:0] rsp_power_db,
   output logic                              rsp_accepted
);
   import bpadb_pkg::*;

   // Stage positions
   localparam int ST_A = 0;
   localparam int ST_B = 1;
   localparam int ST_C = 2;
   localparam int ST_D = ST_C + FRAC_W + 1;
   localparam int ST_E = ST_D + 1;
   localparam int ST_F = ST_E + 1;
   localparam int NST  = ST_F + 1;

   typedef struct packed {
      meta_type           meta;
      logic [SUM_W-1:0]   sum;
      logic [TGT_W-1:0]   div;
      logic [SE_W-1:0]    lz_s;
      logic [DE_W-1:0]    lz_d;
   } norm_type;

   typedef struct packed {
      meta_type           meta;
      logic [SE_W-1:0]    e_s;
      logic [DE_W-1:0]    e_d;
      logic [MANT_W-1:0]  m_s;
      logic [MANT_W-1:0]  m_d;
      logic [FRAC_W-1:0]  f_s;
      logic [FRAC_W-1:0]  f_d;
   } sq_type;

   typedef struct packed {
      meta_type           meta;
      logic               neg;
      logic [ABS_W-1:0]   absd;
   } dlog_type;

   typedef struct packed {
      meta_type           meta;
      logic               neg;
      logic [MAG_W-1:0]   mag;
   } mag_type;

   typedef struct packed {
      meta_type           meta;
      logic [DB_W-1:0]    db;
   } res_type;

   logic [NST-1:0] v_ff, v_in, prev_v, ld;
   logic [NST:0]   rdy;

   job_type  a_ff, a_in;
   norm_type b_ff, b_in;
   sq_type   sq_ff [FRAC_W+1];
   sq_type   sq_in [FRAC_W+1];
   dlog_type d_ff, d_in;
   mag_type  e_ff, e_in;
   res_type  f_ff, f_in;

   // Leading zeros of a bin sum
   function automatic logic [SE_W-1:0] lz_sum(input logic [SUM_W-1:0] x);
      logic [SE_W-1:0] n;
      n = '0;
      for (int i = 0; i < SUM_W; i++) begin
         if (x[i]) n = SE_W'(SUM_W - 1 - i);
      end
      return n;
   endfunction

   // Leading zeros of a block count
   function automatic logic [DE_W-1:0] lz_div(input logic [TGT_W-1:0] x);
      logic [DE_W-1:0] n;
      n = '0;
      for (int i = 0; i < TGT_W; i++) begin
         if (x[i]) n = DE_W'(TGT_W - 1 - i);
      end
      return n;
   endfunction

   // Stall each stage only when it is full and the next one holds
   assign rdy[NST] = rsp_ready;
   for (genvar k = 0; k < NST; k++) begin : g_rdy
      assign rdy[k] = !v_ff[k] || rdy[k+1];
   end

   assign prev_v    = {v_ff[NST-2:0], job_valid};
   assign ld        = rdy[NST-1:0] & prev_v;
   assign v_in      = (rdy[NST-1:0] & prev_v) | (~rdy[NST-1:0] & v_ff);
   assign job_ready = rdy[ST_A];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Stage A: take the word
   assign a_in = job;

   // Stage B: find the leading one of both operands
   always_comb begin
      b_in.meta = a_ff.meta;
      b_in.sum  = a_ff.sum;
      b_in.div  = a_ff.div;
      b_in.lz_s = lz_sum(a_ff.sum);
      b_in.lz_d = lz_div(a_ff.div);
   end

   // Stage C: normalise both mantissas to Q1.30
   always_comb begin
      logic [SUM_W-1:0] ns;
      logic [TGT_W-1:0] nd;
      ns = b_ff.sum << b_ff.lz_s;
      nd = b_ff.div << b_ff.lz_d;
      sq_in[0].meta = b_ff.meta;
      sq_in[0].e_s  = SE_W'(SUM_W - 1) - b_ff.lz_s;
      sq_in[0].e_d  = DE_W'(TGT_W - 1) - b_ff.lz_d;
      sq_in[0].m_s  = ns[SUM_W-1 -: MANT_W];
      sq_in[0].m_d  = {nd, {(MANT_W - TGT_W){1'b0}}};
      sq_in[0].f_s  = '0;
      sq_in[0].f_d  = '0;
   end

   // Squaring stages: one fraction bit of each log per stage
   for (genvar j = 1; j <= FRAC_W; j++) begin : g_sq
      logic [2*MANT_W-1:0] ps;
      logic [2*MANT_W-1:0] pd;
      logic                bs;
      logic                bd;

      always_comb begin
         ps = sq_ff[j-1].m_s * sq_ff[j-1].m_s;
         pd = sq_ff[j-1].m_d * sq_ff[j-1].m_d;
         bs = ps[2*MANT_W-1];
         bd = pd[2*MANT_W-1];
         sq_in[j].meta = sq_ff[j-1].meta;
         sq_in[j].e_s  = sq_ff[j-1].e_s;
         sq_in[j].e_d  = sq_ff[j-1].e_d;
         sq_in[j].m_s  = bs ? ps[2*MANT_W-1 -: MANT_W] : ps[2*MANT_W-2 -: MANT_W];
         sq_in[j].m_d  = bd ? pd[2*MANT_W-1 -: MANT_W] : pd[2*MANT_W-2 -: MANT_W];
         sq_in[j].f_s  = {sq_ff[j-1].f_s[FRAC_W-2:0], bs};
         sq_in[j].f_d  = {sq_ff[j-1].f_d[FRAC_W-2:0], bd};
      end

      always_ff @(posedge clock) begin
         if (ld[ST_C+j]) begin
            sq_ff[j] <= sq_in[j];
         end
      end
   end

   // Stage D: log2 of the Q8.24 average, split into sign and magnitude
   always_comb begin
      logic [D_W-1:0] dl;
      dl = D_W'({sq_ff[FRAC_W].e_s, sq_ff[FRAC_W].f_s})
         - D_W'({sq_ff[FRAC_W].e_d, sq_ff[FRAC_W].f_d})
         - D_W'(LOG_OFS << FRAC_W);
      d_in.meta = sq_ff[FRAC_W].meta;
      d_in.neg  = dl[D_W-1];
      d_in.absd = dl[D_W-1] ? ABS_W'(-dl) : dl[ABS_W-1:0];
   end

   // Stage E: scale to dB
   always_comb begin
      e_in.meta = d_ff.meta;
      e_in.neg  = d_ff.neg;
      e_in.mag  = MAG_W'(d_ff.absd) * MAG_W'(DB_C);
   end

   // Stage F: round half away from zero, saturate, pick the result word
   always_comb begin
      logic [MAG_W:0]         rnd;
      logic [MAG_W-DB_SHIFT:0] q;
      logic [DB_W-2:0]        sat;
      logic [DB_W-1:0]        mag16;
      rnd   = {1'b0, e_ff.mag} + ((MAG_W+1)'(1) << (DB_SHIFT - 1));
      q     = rnd[MAG_W:DB_SHIFT];
      sat   = (q > (MAG_W-DB_SHIFT+1)'(DB_MAX)) ? DB_MAX : q[DB_W-2:0];
      mag16 = {1'b0, sat};
      f_in.meta = e_ff.meta;
      if (e_ff.meta.kind == KIND_BEGIN) begin
         f_in.db = '0;
      end else if (e_ff.meta.zero) begin
         f_in.db = DB_ZERO;
      end else begin
         f_in.db = e_ff.neg ? (~mag16 + DB_W'(1)) : mag16;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ld[ST_A]) a_ff     <= a_in;
      if (ld[ST_B]) b_ff     <= b_in;
      if (ld[ST_C]) sq_ff[0] <= sq_in[0];
      if (ld[ST_D]) d_ff     <= d_in;
      if (ld[ST_E]) e_ff     <= e_in;
      if (ld[ST_F]) f_ff     <= f_in;
   end

   // Result word
   assign rsp_valid    = v_ff[ST_F];
   assign rsp_kind     = f_ff.meta.kind;
   assign rsp_out_bin  = f_ff.meta.bin;
   assign rsp_power_db = f_ff.db;
   assign rsp_accepted = f_ff.meta.accepted;

endmodule

/* rtl/bin_power_average_db.sv */
// Per-bin power averager with a dB result. Bin power words (Q8.24) are
// summed per bin into a 64-entry store of 48-bit sums; in the final block of
// a frequency step each bin word returns 10*log10(sum/blocks) as Q8.8 dB and
// clears its sum, and a begin word returns a status telling whether the new
// frequency was taken. One word is accepted every cycle, sustained, as long as
// results are taken: the store is read at acceptance and written back when the
// word leaves the store stage, with a forwarding path for the same bin on
// back-to-back words. Results pass the store stage and the log2 pipeline
// (input register, leading-one search, normalise, sixteen squaring stages,
// log difference, one 23x18 multiply, rounding). Words that give no result
// add no delay. An accepted begin clears the store by valid bits, so there is
// no clearing pass after reset.
module bin_power_average_db (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [bpadb_pkg::BIN_W-1:0]       req_bin_index,
   input  logic [bpadb_pkg::POW_W-1:0]       req_linear_power,
   input  logic [bpadb_pkg::FREQ_W-1:0]      req_frequency,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_kind,
   output logic [bpadb_pkg::BIN_W-1:0]       rsp_out_bin,
   output logic signed [bpadb_pkg::DB_W-1:0] rsp_power_db,
   output logic                              rsp_accepted,
   input  logic                              csr_write_en,
   input  logic [bpadb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpadb_pkg::CSR_W-1:0]       csr_write_data
);
   import bpadb_pkg::*;

   logic    job_valid;
   logic    job_ready;
   job_type job;

   // Accumulate sums and decide results
   bpadb_acc u_acc (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_bin_index    (req_bin_index),
      .req_linear_power (req_linear_power),
      .req_frequency    (req_frequency),
      .job_valid        (job_valid),
      .job_ready        (job_ready),
      .job              (job)
   );

   // Convert to dB and hold the result word
   bpadb_db_pipe u_pipe (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job_ready    (job_ready),
      .job          (job),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_out_bin  (rsp_out_bin),
      .rsp_power_db (rsp_power_db),
      .rsp_accepted (rsp_accepted)
   );

endmodule

/* rtl/bpadb_checker.sv */
// Port-level checks on the result channel of the averager, bound to the top.
module bpadb_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_kind,
   input  logic [bpadb_pkg::BIN_W-1:0]       rsp_out_bin,
   input  logic signed [bpadb_pkg::DB_W-1:0] rsp_power_db,
   input  logic                              rsp_accepted
);
   import bpadb_pkg::*;

   // A begin status carries no bin and no power
   a_begin_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_BEGIN)) |-> ((rsp_out_bin == '0) && (rsp_power_db == '0)))
      else $error("begin status with bin or power set");

   // A bin result never reports a taken begin
   a_bin_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_BIN)) |-> !rsp_accepted)
      else $error("bin result with accepted flag set");

   // Hold a stalled result word
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_kind) && $stable(rsp_out_bin)
          && $stable(rsp_power_db) && $stable(rsp_accepted)))
      else $error("stalled result word changed");

   // Drop every pending result on reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind bin_power_average_db bpadb_checker u_bpadb_checker (.*);

/* test/bin_power_average_db_tb.sv */
// Self-checking testbench for the bin power averager: directed words, then random blocks.
`timescale 1ns / 1ps

module bin_power_average_db_tb;
   import bpadb_pkg::*;

   localparam int RUN_LIMIT = 1000000;   // cycles before the run is abandoned
   localparam int SETTLE    = 40;        // pipeline depth plus margin
   localparam int HOLD_LEN  = 300;       // long receiver hold-off

   typedef struct packed {
      kind_type          kind;
      logic [BIN_W-1:0]  out_bin;
      logic [DB_W-1:0]   power_db;
      logic              accepted;
   } db_result_type;

   typedef enum logic {
      ROW_WORD  = 1'b0,
      ROW_WRITE = 1'b1
   } row_op_type;

   typedef struct {
      row_op_type        op;
      logic              func;
      logic [BIN_W-1:0]  bin;
      logic [POW_W-1:0]  power;
      logic [FREQ_W-1:0] freq;
      bit                typed;
      db_result_type     want;
      csr_type           idx;
      logic [CSR_W-1:0]  data;
   } stim_row_type;

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   logic                    req_ready;
   logic                    req_func       = 1'b0;
   logic [BIN_W-1:0]        req_bin_index  = '0;
   logic [POW_W-1:0]        req_linear_power = '0;
   logic [FREQ_W-1:0]       req_frequency  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready      = 1'b0;
   logic                    rsp_kind;
   logic [BIN_W-1:0]        rsp_out_bin;
   logic signed [DB_W-1:0]  rsp_power_db;
   logic                    rsp_accepted;
   logic                    csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index      = CSR_BIN_COUNT;
   logic [CSR_W-1:0]        csr_write_data = '0;

   // Shared between the sender and the receiver
   logic                    calm      = 1'b0;
   logic                    hold_go   = 1'b0;
   bit                      hold_done = 1'b0;
   int                      hold_left = 0;
   int unsigned             cycle_count = 0;
   int                      mismatch_count = 0;
   int                      words_sent = 0;

   // Averager state as the testbench sees it
   logic [SUM_W-1:0]        sums_model [BINS];
   logic [TGT_W-1:0]        blocks_seen;
   logic [FREQ_W-1:0]       freq_now;
   logic [CNT_W-1:0]        cfg_bins;
   logic [TGT_W-1:0]        cfg_target;

   db_result_type           pending_db [$];
   stim_row_type            stim_rows [$];

   bin_power_average_db u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_bin_index    (req_bin_index),
      .req_linear_power (req_linear_power),
      .req_frequency    (req_frequency),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_out_bin      (rsp_out_bin),
      .rsp_power_db     (rsp_power_db),
      .rsp_accepted     (rsp_accepted),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // log2 of x >= 1 in Q16, mantissa squared in Q1.30
   function automatic longint log2_q16(input logic [SUM_W-1:0] x);
      int          top;
      logic [63:0] m;
      longint      frac;
      int          i;
      top = 0;
      for (i = 0; i < SUM_W; i++)
         if (x[i]) top = i;
      if (top > 30) m = 64'(x) >> (top - 30);
      else m = 64'(x) << (30 - top);
      frac = 0;
      for (i = 0; i < FRAC_W; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return longint'(top) * 65536 + frac;
   endfunction

   // Q8.8 dB of sum/blocks for a Q8.24 sum, rounded half away from zero
   function automatic logic [DB_W-1:0] level_db(input logic [SUM_W-1:0] sum,
                                                input logic [SUM_W-1:0] blocks);
      longint d;
      longint p;
      longint q;
      if (sum == 0) return DB_ZERO;
      d = log2_q16(sum) - log2_q16(blocks) - longint'(LOG_OFS) * 65536;
      p = d * longint'(DB_C);
      if (p >= 0) q = (p + 64'sd8388608) >>> 24;
      else q = -((-p + 64'sd8388608) >>> 24);
      if (q > 32767) q = 32767;
      if (q < -32767) q = -32767;
      return DB_W'(q);
   endfunction

   task automatic reset_model();
      foreach (sums_model[i]) sums_model[i] = '0;
      blocks_seen = '0;
      freq_now    = '0;
      cfg_bins    = BIN_COUNT_RST;
      cfg_target  = BLOCK_TARGET_RST;
   endtask

   task automatic apply_write(input csr_type idx, input logic [CSR_W-1:0] data);
      if (idx == CSR_BIN_COUNT) cfg_bins = data[CNT_W-1:0];
      else cfg_target = data[TGT_W-1:0];
   endtask

   // Advance the averager by one word; has is set when a result word follows
   task automatic average_word(input logic func, input logic [BIN_W-1:0] bin,
                               input logic [POW_W-1:0] power,
                               input logic [FREQ_W-1:0] freq,
                               output bit has, output db_result_type res);
      logic [CNT_W-1:0] eff;
      logic [SUM_W:0]   grown;
      logic [TGT_W:0]   next_blk;
      bit               ok;
      has = 1'b0;
      res = '0;
      eff = (cfg_bins < BINS) ? cfg_bins : CNT_W'(BINS);
      if (func == FUNC_BEGIN) begin
         ok = !(blocks_seen != 0 && freq_now == freq);
         if (ok) begin
            foreach (sums_model[i]) sums_model[i] = '0;
            blocks_seen = '0;
            freq_now    = freq;
         end
         has          = 1'b1;
         res.kind     = KIND_BEGIN;
         res.accepted = ok;
         return;
      end
      if (eff == 0 || cfg_target == 0 || {1'b0, bin} >= eff) return;
      grown = {1'b0, sums_model[bin]} + power;
      sums_model[bin] = grown[SUM_W] ? SUM_MAX : grown[SUM_W-1:0];
      next_blk = blocks_seen + 1'b1;
      // not yet the final block: only the last bin closes one
      if (next_blk < cfg_target) begin
         if ({1'b0, bin} == eff - 1'b1) blocks_seen = blocks_seen + 1'b1;
         return;
      end
      has          = 1'b1;
      res.kind     = KIND_BIN;
      res.out_bin  = bin;
      res.power_db = level_db(sums_model[bin], SUM_W'(next_blk));
      sums_model[bin] = '0;
      if ({1'b0, bin} == eff - 1'b1) blocks_seen = '0;
   endtask

   function automatic logic [POW_W-1:0] pick_power();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 4) return '0;
      if (sel < 8) return '1;
      return $urandom >> $urandom_range(0, 31);
   endfunction

   function automatic logic [FREQ_W-1:0] pick_freq();
      return {8'($urandom_range(0, 255)), 32'($urandom)};
   endfunction

   function automatic stim_row_type word_row(input logic func, input logic [BIN_W-1:0] bin,
                                             input logic [POW_W-1:0] power,
                                             input logic [FREQ_W-1:0] freq);
      stim_row_type r;
      r = '{op: ROW_WORD, func: func, bin: bin, power: power, freq: freq,
            typed: 1'b0, want: '0, idx: CSR_BIN_COUNT, data: '0};
      return r;
   endfunction

   function automatic stim_row_type typed_row(input logic func, input logic [BIN_W-1:0] bin,
                                              input logic [POW_W-1:0] power,
                                              input logic [FREQ_W-1:0] freq,
                                              input kind_type kind,
                                              input logic [DB_W-1:0] db,
                                              input logic acc);
      stim_row_type r;
      r = word_row(func, bin, power, freq);
      r.typed          = 1'b1;
      r.want.kind      = kind;
      r.want.out_bin   = (kind == KIND_BIN) ? bin : '0;
      r.want.power_db  = db;
      r.want.accepted  = acc;
      return r;
   endfunction

   function automatic stim_row_type write_row(input csr_type idx,
                                              input logic [CSR_W-1:0] data);
      stim_row_type r;
      r = word_row(FUNC_SAMPLE, '0, '0, '0);
      r.op   = ROW_WRITE;
      r.idx  = idx;
      r.data = data;
      return r;
   endfunction

   // Offer one word, hold it until taken, then predict its result
   task automatic drive_word(input logic func, input logic [BIN_W-1:0] bin,
                             input logic [POW_W-1:0] power, input logic [FREQ_W-1:0] freq,
                             input bit typed, input db_result_type typed_res);
      bit            has;
      db_result_type res;
      if (!calm && $urandom_range(0, 99) < 5) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_bin_index    <= bin;
      req_linear_power <= power;
      req_frequency    <= freq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      average_word(func, bin, power, freq, has, res);
      if (has) pending_db.push_back(typed ? typed_res : res);
      words_sent++;
   endtask

   task automatic send_sample(input logic [BIN_W-1:0] bin, input logic [POW_W-1:0] power);
      drive_word(FUNC_SAMPLE, bin, power, pick_freq(), 1'b0, '0);
   endtask

   task automatic send_begin(input logic [FREQ_W-1:0] freq);
      drive_word(FUNC_BEGIN, BIN_W'($urandom_range(0, 63)), $urandom, freq, 1'b0, '0);
   endtask

   // Drop valid and wait for every expected result word
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_db.size() != 0) @(posedge clock);
   endtask

   // Quiet block: nothing expected and the pipeline flushed of silent words
   task automatic settle();
      drain();
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_type idx, input logic [CSR_W-1:0] data);
      settle();
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      apply_write(idx, data);
      csr_write_en <= 1'b0;
   endtask

   task automatic write_regs(input logic [CNT_W-1:0] cnt, input logic [TGT_W-1:0] tgt);
      settle();
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_BIN_COUNT;
      csr_write_data <= CSR_W'(cnt);
      @(posedge clock);
      apply_write(CSR_BIN_COUNT, CSR_W'(cnt));
      csr_index      <= CSR_BLOCK_TARGET;
      csr_write_data <= CSR_W'(tgt);
      @(posedge clock);
      apply_write(CSR_BLOCK_TARGET, CSR_W'(tgt));
      csr_write_en <= 1'b0;
   endtask

   // One random setting followed by mostly well-formed blocks with some noise
   task automatic run_phase(input int phase_no);
      logic [CNT_W-1:0] cnt;
      logic [TGT_W-1:0] tgt;
      int               eff;
      int               span;
      int               blocks;
      int               b;
      int               k;
      int               sel;
      calm <= (phase_no >= 4 && phase_no < 7);
      sel = $urandom_range(0, 99);
      if (sel < 5) cnt = '0;
      else if (sel < 12) cnt = CNT_W'(64);
      else if (sel < 17) cnt = CNT_W'($urandom_range(65, 127));
      else if (sel < 25) cnt = CNT_W'(1);
      else cnt = CNT_W'($urandom_range(2, 12));
      sel = $urandom_range(0, 99);
      if (sel < 4) tgt = '0;
      else if (sel < 9) tgt = TGT_W'(65536);
      else if (sel < 20) tgt = TGT_W'($urandom_range(5, 24));
      else tgt = TGT_W'($urandom_range(1, 4));
      write_regs(cnt, tgt);
      // without a begin the step carries on under the new target
      if ($urandom_range(0, 3) != 0) send_begin(pick_freq());
      eff  = (cnt > 64) ? 64 : int'(cnt);
      span = (eff == 0) ? 8 : eff;
      if (tgt != 0 && tgt <= 24) blocks = $urandom_range(1, 2 * int'(tgt) + 1);
      else blocks = $urandom_range(1, 8);
      if (blocks * span > 160) blocks = (160 / span < 1) ? 1 : 160 / span;
      for (k = 0; k < blocks; k++) begin
         for (b = 0; b < span; b++) begin
            sel = $urandom_range(0, 99);
            if (sel < 88) send_sample(BIN_W'(b), pick_power());
            else if (sel < 93) send_sample(BIN_W'($urandom_range(0, 63)), pick_power());
            else if (sel < 96) send_begin($urandom_range(0, 1) ? freq_now : pick_freq());
            else if (sel < 98) begin
               send_sample(BIN_W'(b), pick_power());
               send_sample(BIN_W'(b), pick_power());
            end
            // otherwise skip this bin
         end
      end
      if ($urandom_range(0, 2) == 0) send_begin(freq_now);
   endtask

   // Receiver: random stalls, one long hold-off, and a calm stretch
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_LEN;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 10);
      end
   end

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin : check_results
      db_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_db.size() == 0) begin
            $error("unexpected result word: kind %0d bin %0d", rsp_kind, rsp_out_bin);
            mismatch_count++;
         end else begin
            want = pending_db.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               mismatch_count++;
            end
            if (rsp_out_bin !== want.out_bin) begin
               $error("out_bin: expected %0d, got %0d", want.out_bin, rsp_out_bin);
               mismatch_count++;
            end
            if (rsp_power_db !== want.power_db) begin
               $error("power_db: expected %0d, got %0d", $signed(want.power_db), rsp_power_db);
               mismatch_count++;
            end
            if (rsp_accepted !== want.accepted) begin
               $error("accepted: expected %0d, got %0d", want.accepted, rsp_accepted);
               mismatch_count++;
            end
         end
      end
   end

   // Abandon a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("bin_power_average_db regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int start;
      int phase_no;
      int n;
      reset_model();

      // Reset values: 64 bins, one block per step
      stim_rows.push_back(typed_row(FUNC_BEGIN, '0, '0, '0, KIND_BEGIN, '0, 1'b1));
      stim_rows.push_back(typed_row(FUNC_BEGIN, '0, '1, '1, KIND_BEGIN, '0, 1'b1));
      stim_rows.push_back(typed_row(FUNC_SAMPLE, 6'd0, '0, '0, KIND_BIN, DB_ZERO, 1'b0));
      stim_rows.push_back(typed_row(FUNC_SAMPLE, 6'd63, 32'h0100_0000, '1,
                                    KIND_BIN, '0, 1'b0));
      stim_rows.push_back(word_row(FUNC_SAMPLE, 6'd63, '1, '0));
      stim_rows.push_back(word_row(FUNC_SAMPLE, 6'd0, 32'd1, '0));
      stim_rows.push_back(word_row(FUNC_SAMPLE, 6'd21, 32'h5555_5555, 40'hAA_AAAA_AAAA));
      stim_rows.push_back(word_row(FUNC_SAMPLE, 6'd42, 32'hAAAA_AAAA, 40'h55_5555_5555));
      // Two bins, three blocks: rejection of a repeated frequency, out of order bins
      stim_rows.push_back(write_row(CSR_BIN_COUNT, 17'd2));
      stim_rows.push_back(write_row(CSR_BLOCK_TARGET, 17'd3));
      stim_rows.push_back(typed_row(FUNC_BEGIN, '0, '0, 40'd7, KIND_BEGIN, '0, 1'b1));
      stim_rows.push_back(word_row(FUNC_SAMPLE, 6'd0, 32'h0300_0000, '0));
      stim_rows.push_back(word_row(FUNC_SAMPLE, 6'd1, 32'h0040_0000, '0));
      stim_rows.push_back(typed_row(FUNC_BEGIN, '0, '0, 40'd7, KIND_BEGIN, '0, 1'b0));
      stim_rows.push_back(typed_row(FUNC_BEGIN, '0, '0, 40'd8, KIND_BEGIN, '0, 1'b1));
      stim_rows.push_back(word_row(FUNC_SAMPLE, 6'd1, 32'h1234_5678, '0));
      stim_rows.push_back(word_row(FUNC_SAMPLE, 6'd1, 32'h0000_FFFF, '0));
      stim_rows.push_back(word_row(FUNC_SAMPLE, 6'd5, '1, '0));
      stim_rows.push_back(word_row(FUNC_SAMPLE, 6'd0, 32'h0900_0000, '0));
      stim_rows.push_back(word_row(FUNC_SAMPLE, 6'd1, 32'h8000_0000, '0));
      // Zero bin count, oversized bin count, zero and largest target
      stim_rows.push_back(write_row(CSR_BIN_COUNT, 17'd0));
      stim_rows.push_back(word_row(FUNC_SAMPLE, 6'd0, '1, '0));
      stim_rows.push_back(write_row(CSR_BIN_COUNT, 17'd100));
      stim_rows.push_back(write_row(CSR_BLOCK_TARGET, 17'd0));
      stim_rows.push_back(word_row(FUNC_SAMPLE, 6'd10, '1, '0));
      stim_rows.push_back(write_row(CSR_BLOCK_TARGET, 17'd65536));
      stim_rows.push_back(word_row(FUNC_SAMPLE, 6'd63, '1, '0));
      stim_rows.push_back(typed_row(FUNC_BEGIN, '0, '0, 40'd8, KIND_BEGIN, '0, 1'b0));
      stim_rows.push_back(typed_row(FUNC_BEGIN, '0, '0, 40'd9, KIND_BEGIN, '0, 1'b1));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed rows
      foreach (stim_rows[r]) begin
         if (stim_rows[r].op == ROW_WRITE) begin
            write_reg(stim_rows[r].idx, stim_rows[r].data);
         end else begin
            drive_word(stim_rows[r].func, stim_rows[r].bin, stim_rows[r].power,
                       stim_rows[r].freq, stim_rows[r].typed, stim_rows[r].want);
         end
      end

      // Back-pressure: receiver holds off while one result per word piles up
      start = words_sent;
      write_regs(CNT_W'(16), TGT_W'(1));
      hold_go <= 1'b1;
      for (n = 0; n < 120; n++) begin
         send_sample(BIN_W'(n % 16), pick_power());
         if (n == 60) drain();
      end

      phase_no = 1;
      while (words_sent - start < 1450) begin
         run_phase(phase_no);
         phase_no++;
      end
      calm <= 1'b0;

      drain();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("bin_power_average_db regression: pass");
      else
         $display("bin_power_average_db regression: fail");
      $finish;
   end

endmodule

/* bin_power_average_db.f */
rtl/bpadb_pkg.sv
rtl/bpadb_acc.sv
rtl/bpadb_db_pipe.sv
rtl/bin_power_average_db.sv
rtl/bpadb_checker.sv
test/bin_power_average_db_tb.sv
